// ----- rtl/oaht_pkg.sv -----
// Shared types, constants and helpers for the open-addressing hash table.
// No dependencies; every other file but oaht_ram refers to this package by scoped names.
`default_nettype none

package oaht_pkg;

  localparam int KEY_W  = 31;
  localparam int MW     = 8;   // width of modular quantities (m <= 255)
  localparam int SLOT_W = 7;
  localparam int WORD_W = 32;
  localparam logic [WORD_W-1:0] EMPTY_MARK = '1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_SIZE = 2'd1;
  localparam logic [1:0] CFG_LIN  = 2'd2;
  localparam logic [1:0] CFG_QUAD = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  typedef struct packed {
    logic       probe_mode;
    logic [7:0] table_size;
    logic [9:0] lin_coef;
    logic [9:0] quad_coef;
  } cfg_t;

  // One classified request, ready for the probe walk.
  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [MW-1:0]    m;
    logic [MW-1:0]    base;  // first probe slot
    logic [MW-1:0]    d0;    // first probe step
    logic [MW-1:0]    dd;    // step increment (0 for double hashing)
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_DONE} back_state_t;

  typedef logic [MW-1:0] prime_tab_t [256];

  // Largest prime strictly below m (1 counted as prime), built by a sieve.
  function automatic prime_tab_t build_prime_tab();
    prime_tab_t tab;
    logic comp [256];
    int best;
    for (int v = 0; v < 256; v++) comp[v] = 1'b0;
    for (int p = 2; p < 256; p++) begin
      for (int q = p + p; q < 256; q = q + p) comp[q] = 1'b1;
    end
    best = 1;
    for (int v = 0; v < 256; v++) begin
      tab[v] = MW'(best);
      if (v >= 2 && !comp[v]) best = v;
    end
    return tab;
  endfunction

  localparam prime_tab_t PRIME_BELOW = build_prime_tab();

  // (a + b) mod m for a, b < m.
  function automatic logic [MW-1:0] mod_add(logic [MW-1:0] a, logic [MW-1:0] b,
                                            logic [MW-1:0] m);
    logic [MW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/oaht_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/oaht_front.sv -----
// Front end: accepts requests, reduces key and coefficients modulo m and R
// with a bit-serial divider, and hands a job to the queue. Uses oaht_pkg.
`default_nettype none

module oaht_front #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               enable,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire oaht_pkg::req_t     in_data,
  input  wire oaht_pkg::cfg_t     cfg,
  output logic                    job_valid,
  input  wire logic               job_ready,
  output oaht_pkg::job_t          job
);

  localparam int NL = 4;  // key mod m, key mod R, c1 mod m, c2 mod m

  oaht_pkg::front_state_t state, state_next;
  oaht_pkg::req_t         cur;
  logic [oaht_pkg::MW-1:0]    m, r;
  logic [oaht_pkg::MW-1:0]    m_eff;
  logic [oaht_pkg::KEY_W-1:0] dvd [NL];
  logic [oaht_pkg::MW-1:0]    rem [NL];
  logic [oaht_pkg::MW-1:0]    rem_next [NL];
  logic [4:0]                 cnt;
  logic                       accept;
  logic [oaht_pkg::MW-1:0]    step, d_quad, dd_quad;

  always_comb begin
    if (cfg.table_size < 8'd2) m_eff = oaht_pkg::MW'(2);
    else if (int'(cfg.table_size) > TABLE_DEPTH) m_eff = oaht_pkg::MW'(TABLE_DEPTH);
    else m_eff = cfg.table_size;
  end

  assign accept = in_valid && !in_stall;

  // one quotient bit per cycle in each lane
  always_comb begin
    logic [oaht_pkg::MW:0] t;
    logic [oaht_pkg::MW:0] dv;
    for (int l = 0; l < NL; l++) begin
      t  = {rem[l], dvd[l][oaht_pkg::KEY_W-1]};
      dv = {1'b0, (l == 1) ? r : m};
      if (t >= dv) t = t - dv;
      rem_next[l] = t[oaht_pkg::MW-1:0];
    end
  end

  assign step    = r - rem[1];
  assign d_quad  = oaht_pkg::mod_add(rem[2], rem[3], m);
  assign dd_quad = oaht_pkg::mod_add(rem[3], rem[3], m);

  always_comb begin
    job.req_type = cur.req_type;
    job.key      = cur.key;
    job.m        = m;
    job.base     = rem[0];
    job.d0       = cfg.probe_mode ? step : d_quad;
    job.dd       = cfg.probe_mode ? '0 : dd_quad;
  end

  always_comb begin
    state_next = state;
    case (state)
      oaht_pkg::F_IDLE: if (accept) state_next = oaht_pkg::F_DIV;
      oaht_pkg::F_DIV:  if (cnt == 5'(oaht_pkg::KEY_W - 1)) state_next = oaht_pkg::F_PUSH;
      oaht_pkg::F_PUSH: if (job_ready) state_next = oaht_pkg::F_IDLE;
      default:          state_next = oaht_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = !(state == oaht_pkg::F_IDLE && enable);
    job_valid = (state == oaht_pkg::F_PUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= oaht_pkg::F_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur    <= in_data;
      m      <= m_eff;
      r      <= oaht_pkg::PRIME_BELOW[m_eff];
      dvd[0] <= in_data.key;
      dvd[1] <= in_data.key;
      dvd[2] <= oaht_pkg::KEY_W'(cfg.lin_coef);
      dvd[3] <= oaht_pkg::KEY_W'(cfg.quad_coef);
      for (int l = 0; l < NL; l++) rem[l] <= '0;
      cnt    <= '0;
    end else if (state == oaht_pkg::F_DIV) begin
      for (int l = 0; l < NL; l++) begin
        rem[l] <= rem_next[l];
        dvd[l] <= {dvd[l][oaht_pkg::KEY_W-2:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/oaht_fifo.sv -----
// Two-entry job queue between front and back end. Uses oaht_pkg.
`default_nettype none

module oaht_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire oaht_pkg::job_t push_data,
  input  wire logic           pop,
  output oaht_pkg::job_t      head,
  output logic                full,
  output logic                empty
);

  oaht_pkg::job_t entry [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= push_data;
  end

endmodule

`default_nettype wire

// ----- rtl/oaht_back.sv -----
// Back end: clears the slot store after reset, walks probe sequences with one
// read issued per cycle, updates the store and holds the result. Uses oaht_pkg, oaht_ram.
`default_nettype none

module oaht_back #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire oaht_pkg::job_t job,
  input  wire logic           job_valid,
  output logic                job_pop,
  output logic                clearing,
  output logic                out_valid,
  input  wire logic           out_stall,
  output oaht_pkg::rsp_t      out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  oaht_pkg::back_state_t state, state_next;
  oaht_pkg::job_t          cur;
  oaht_pkg::rsp_t          res;
  logic [oaht_pkg::MW-1:0] pos, d, iss, ev_slot;
  logic                    ev_valid, ev_last;
  logic [AW-1:0]           clr_idx;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [oaht_pkg::WORD_W-1:0] wdata, rdata;
  logic                    match, miss_end, issue, out_load;

  oaht_ram #(.WIDTH(oaht_pkg::WORD_W), .DEPTH(TABLE_DEPTH)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(AW'(pos)),
    .rdata(rdata)
  );

  always_comb begin
    if (cur.req_type == oaht_pkg::REQ_INSERT)
      match = ev_valid && (rdata == oaht_pkg::EMPTY_MARK);
    else
      match = ev_valid && (rdata == {1'b0, cur.key});
  end

  assign miss_end = ev_valid && !match && ev_last;
  assign issue    = (iss < cur.m);
  assign out_load = (state == oaht_pkg::B_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      oaht_pkg::B_CLEAR:
        if (clr_idx == AW'(TABLE_DEPTH - 1)) state_next = oaht_pkg::B_IDLE;
      oaht_pkg::B_IDLE:
        if (job_valid) begin
          if (job.req_type == oaht_pkg::REQ_RSVD) state_next = oaht_pkg::B_DONE;
          else state_next = oaht_pkg::B_PROBE;
        end
      oaht_pkg::B_PROBE:
        if (match || miss_end) state_next = oaht_pkg::B_DONE;
      oaht_pkg::B_DONE:
        if (out_load) state_next = oaht_pkg::B_IDLE;
      default: state_next = oaht_pkg::B_CLEAR;
    endcase
  end

  always_comb begin
    job_pop  = (state == oaht_pkg::B_IDLE) && job_valid;
    clearing = (state == oaht_pkg::B_CLEAR);
    we       = 1'b0;
    waddr    = clr_idx;
    wdata    = oaht_pkg::EMPTY_MARK;
    case (state)
      oaht_pkg::B_CLEAR: we = 1'b1;
      oaht_pkg::B_PROBE: begin
        waddr = AW'(ev_slot);
        if (match && cur.req_type != oaht_pkg::REQ_SEARCH) begin
          we = 1'b1;
          if (cur.req_type == oaht_pkg::REQ_INSERT) wdata = {1'b0, cur.key};
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oaht_pkg::B_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == oaht_pkg::B_CLEAR) clr_idx <= clr_idx + AW'(1);
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
    if (job_pop) begin
      cur      <= job;
      pos      <= job.base;
      d        <= job.d0;
      iss      <= '0;
      ev_valid <= 1'b0;
      ev_last  <= 1'b0;
      res      <= '{status: oaht_pkg::ST_NOT_FOUND, slot: '0};
    end else if (state == oaht_pkg::B_PROBE) begin
      // reads run one ahead of the compare; a read past the hit is dropped
      ev_valid <= issue;
      if (issue) begin
        pos     <= oaht_pkg::mod_add(pos, d, cur.m);
        d       <= oaht_pkg::mod_add(d, cur.dd, cur.m);
        iss     <= iss + oaht_pkg::MW'(1);
        ev_slot <= pos;
        ev_last <= (iss == cur.m - oaht_pkg::MW'(1));
      end
      if (match)
        res <= '{status: oaht_pkg::ST_DONE, slot: ev_slot[oaht_pkg::SLOT_W-1:0]};
      else if (miss_end)
        res <= '{status: (cur.req_type == oaht_pkg::REQ_INSERT) ? oaht_pkg::ST_FULL
                                                                 : oaht_pkg::ST_NOT_FOUND,
                 slot: '0};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/open_addressing_hash_table.sv -----
// Top level of the open-addressing hash table: configuration registers,
// front end, job queue and back end. Uses oaht_pkg, oaht_front, oaht_fifo, oaht_back.
//
// Usage:
//   Requests (insert, search, delete of a 31-bit key) enter on in_valid/in_stall;
//   each yields one response (status, slot) on out_valid/out_stall.
//   Registers are written on cfg_valid/cfg_ready (always ready) by index:
//   0 probe mode, 1 table size, 2 linear coefficient, 3 square coefficient.
//   Write them only while no request is in flight.
//   The front holds a request through accept, 31 divider bit steps and hand-off;
//   the back end then pops the job, issues one store read per cycle (at most m
//   reads, each compared in the cycle after it is issued) and loads the response
//   once the output register is free. The front takes a new request only after
//   handing off the last one, and it can divide while the back end walks the
//   previous probe sequence through the single store read port.
//   After reset the back end clears the store, one slot per cycle, and in_stall
//   is high during that pass.
//   When out_stall is high the response is held; the back end waits with the next
//   result, while the front and the two-entry queue take requests until full.
`default_nettype none

module open_addressing_hash_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire oaht_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output oaht_pkg::rsp_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [9:0]     cfg_data
);

  oaht_pkg::cfg_t cfg;
  oaht_pkg::job_t job_in, job_head;
  logic job_valid, q_full, q_empty, q_push, q_pop, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.probe_mode <= 1'b0;
      cfg.table_size <= 8'd16;
      cfg.lin_coef   <= 10'd1;
      cfg.quad_coef  <= 10'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        oaht_pkg::CFG_MODE: cfg.probe_mode <= cfg_data[0];
        oaht_pkg::CFG_SIZE: cfg.table_size <= cfg_data[7:0];
        oaht_pkg::CFG_LIN:  cfg.lin_coef   <= cfg_data;
        oaht_pkg::CFG_QUAD: cfg.quad_coef  <= cfg_data;
        default: ;
      endcase
    end
  end

  oaht_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .enable   (!clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .job_valid(job_valid),
    .job_ready(!q_full),
    .job      (job_in)
  );

  assign q_push = job_valid && !q_full;

  oaht_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(job_in),
    .pop      (q_pop),
    .head     (job_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  oaht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_head),
    .job_valid(!q_empty),
    .job_pop  (q_pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall) else $error("request accepted during store clear");

  a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != oaht_pkg::ST_DONE) |-> (out_data.slot == '0))
    else $error("nonzero slot on failed request");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push) else $error("job queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("job queue underflow");

endmodule

`default_nettype wire
